FILE: rtl/core/hdp_pkg.sv
// Shared types, constants and helper functions of the HTTP date parser.
package hdp_pkg;

   localparam int MAX_TEXT = 127;
   localparam int CNT_W    = $clog2(MAX_TEXT + 1);
   localparam int MAG_W    = 17;
   localparam int NUM_W    = MAG_W + 1;
   localparam logic [MAG_W-1:0] NUM_SAT = 17'd131071;
   localparam logic [3:0] MON_NONE = 4'd12;
   localparam int EPOCH_W  = 43;

   // Number reader phases
   typedef enum logic [1:0] {
      RD_LEAD = 2'd0,
      RD_DIG  = 2'd1,
      RD_STOP = 2'd2
   } rd_phase_type;

   typedef struct packed {
      rd_phase_type      phase;
      logic              neg;
      logic [MAG_W-1:0]  mag;
   } num_rd_type;

   localparam num_rd_type RD_INIT = '{phase: RD_LEAD, neg: 1'b0, mag: '0};

   // Token kinds, fixed at the first byte of a token
   typedef enum logic [1:0] {
      TK_NONE  = 2'd0,
      TK_DAY   = 2'd1,
      TK_DIGIT = 2'd2,
      TK_WORD  = 2'd3
   } tok_kind_type;

   // Parsed fields of one string, handed from front to back
   typedef struct packed {
      logic                     err;
      logic                     have_all;
      logic signed [NUM_W-1:0]  day;
      logic [3:0]               month;
      logic signed [NUM_W-1:0]  year;
      logic [CNT_W-1:0]         ylen;
      logic signed [10:0]       hour;
      logic signed [NUM_W-1:0]  min;
      logic signed [NUM_W-1:0]  sec;
   } fields_type;

   typedef enum logic [2:0] {
      BK_IDLE  = 3'd0,
      BK_PREP  = 3'd1,
      BK_MUL   = 3'd2,
      BK_SUM   = 3'd3,
      BK_SCALE = 3'd4
   } bk_state_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   // One byte into an atoi style reader, magnitude saturating
   function automatic num_rd_type rd_step(input num_rd_type s, input logic [7:0] c);
      num_rd_type r;
      logic [MAG_W+3:0] acc;
      logic [MAG_W-1:0] sat;
      r   = s;
      acc = {4'b0, s.mag} * (MAG_W+4)'(10) + {{MAG_W{1'b0}}, c[3:0]};
      sat = (acc > {4'b0, NUM_SAT}) ? NUM_SAT : acc[MAG_W-1:0];
      unique case (s.phase)
         RD_LEAD: begin
            if (is_space(c)) begin
               r.phase = RD_LEAD;
            end else if (c == 8'h2B || c == 8'h2D) begin
               r.neg   = (c == 8'h2D);
               r.phase = RD_DIG;
            end else if (is_digit(c)) begin
               r.mag   = sat;
               r.phase = RD_DIG;
            end else begin
               r.phase = RD_STOP;
            end
         end
         RD_DIG: begin
            if (is_digit(c)) r.mag = sat;
            else r.phase = RD_STOP;
         end
         default: r = s;
      endcase
      return r;
   endfunction

   function automatic logic signed [NUM_W-1:0] rd_value(input num_rd_type s);
      logic signed [NUM_W-1:0] v;
      v = $signed({1'b0, s.mag});
      return s.neg ? -v : v;
   endfunction

   // Case-folded three letter month name to index
   function automatic logic [3:0] month_match(input logic [23:0] pre);
      logic [7:0] a, b, c;
      a = pre[23:16];
      b = pre[15:8];
      c = pre[7:0];
      if (a >= 8'h61 && a <= 8'h7A) a = a - 8'd32;
      if (b >= 8'h41 && b <= 8'h5A) b = b + 8'd32;
      if (c >= 8'h41 && c <= 8'h5A) c = c + 8'd32;
      unique case ({a, b, c})
         "Jan":   return 4'd0;
         "Feb":   return 4'd1;
         "Mar":   return 4'd2;
         "Apr":   return 4'd3;
         "May":   return 4'd4;
         "Jun":   return 4'd5;
         "Jul":   return 4'd6;
         "Aug":   return 4'd7;
         "Sep":   return 4'd8;
         "Oct":   return 4'd9;
         "Nov":   return 4'd10;
         "Dec":   return 4'd11;
         default: return MON_NONE;
      endcase
   endfunction

   // Days from March 1 to the first of the month, year starting in March
   function automatic logic [8:0] month_offset(input logic [3:0] m);
      unique case (m)
         4'd0:    return 9'd306;
         4'd1:    return 9'd337;
         4'd2:    return 9'd0;
         4'd3:    return 9'd31;
         4'd4:    return 9'd61;
         4'd5:    return 9'd92;
         4'd6:    return 9'd122;
         4'd7:    return 9'd153;
         4'd8:    return 9'd184;
         4'd9:    return 9'd214;
         4'd10:   return 9'd245;
         4'd11:   return 9'd275;
         default: return 9'd0;
      endcase
   endfunction

endpackage

FILE: rtl/core/http_date_parser_unit.sv
// Top level of the HTTP date parser: byte front, field queue, calendar back.
//
//   channel  direction  signals                                    transfer
//   req      in         req_valid req_ready req_char_in req_is_last  one text byte
//   rsp      out        rsp_valid rsp_ready rsp_ok rsp_epoch_seconds one date result
//
// A byte is taken every cycle while the two-entry field queue has room.
// The result is formed by the back end's prep, multiply, sum and scale steps
// and held in its output register; the back end runs once per string.
// Reset empties the queue and output register and clears token length and kind.
// A held result stays in the output register; bytes flow while the queue has room.
module http_date_parser_unit
   import hdp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_char_in,
   input  logic                       req_is_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_ok,
   output logic signed [EPOCH_W-1:0]  rsp_epoch_seconds
);

   logic       push, full, not_empty, pop;
   fields_type push_fields, pop_fields;

   assign req_ready = !full;

   hdp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .take_byte   (req_valid && req_ready),
      .char_in     (req_char_in),
      .is_last     (req_is_last),
      .push        (push),
      .push_fields (push_fields)
   );

   hdp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_fields (push_fields),
      .full        (full),
      .not_empty   (not_empty),
      .pop         (pop),
      .pop_fields  (pop_fields)
   );

   hdp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (not_empty),
      .q_fields          (pop_fields),
      .q_pop             (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ok            (rsp_ok),
      .rsp_epoch_seconds (rsp_epoch_seconds)
   );

endmodule

FILE: rtl/core/hdp_front.sv
// Byte tokenizer: classifies tokens on the fly and collects the date fields.
module hdp_front
   import hdp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        take_byte,
   input  logic [7:0]  char_in,
   input  logic        is_last,
   output logic        push,
   output fields_type  push_fields
);

   // Text and token state
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ended_ff, ended_in;
   tok_kind_type     kind_ff, kind_in;
   logic [CNT_W-1:0] tlen_ff, tlen_in;
   num_rd_type       lead_ff, lead_in;
   num_rd_type       r1_ff, r1_in;
   num_rd_type       r2_ff, r2_in;
   logic [1:0]       dash_ff, dash_in;
   logic [1:0]       colon_ff, colon_in;
   logic [1:0]       seg_ff, seg_in;
   logic [23:0]      pre_ff, pre_in;
   logic [CNT_W-1:0] after_ff, after_in;
   logic [3:0]       d0_ff, d0_in;
   logic [7:0]       b1_ff, b1_in;
   // Collected fields
   logic [5:0]              roles_ff, roles_in;   // wday day month year time zone
   logic                    err_ff, err_in;
   logic signed [NUM_W-1:0] day_ff, day_in;
   logic [3:0]              month_ff, month_in;
   logic signed [NUM_W-1:0] year_ff, year_in;
   logic [CNT_W-1:0]        ylen_ff, ylen_in;
   logic signed [10:0]      hour_ff, hour_in;
   logic signed [NUM_W-1:0] min_ff, min_in;
   logic signed [NUM_W-1:0] sec_ff, sec_in;

   always_comb begin
      logic take, sep, append, close, fresh;
      tok_kind_type k;
      logic [1:0] bdash, bcolon, bseg;
      // defaults
      cnt_in = cnt_ff;     ended_in = ended_ff; kind_in = kind_ff;  tlen_in = tlen_ff;
      lead_in = lead_ff;   r1_in = r1_ff;       r2_in = r2_ff;      dash_in = dash_ff;
      colon_in = colon_ff; seg_in = seg_ff;     pre_in = pre_ff;    after_in = after_ff;
      d0_in = d0_ff;       b1_in = b1_ff;       roles_in = roles_ff; err_in = err_ff;
      day_in = day_ff;     month_in = month_ff; year_in = year_ff;  ylen_in = ylen_ff;
      hour_in = hour_ff;   min_in = min_ff;     sec_in = sec_ff;
      k = kind_ff;         bdash = dash_ff;     bcolon = colon_ff;  bseg = seg_ff;
      push = 1'b0;

      take   = take_byte && !ended_ff && (cnt_ff < CNT_W'(MAX_TEXT));
      sep    = (char_in == 8'h00) || (char_in == 8'h2C) || (char_in == 8'h20);
      append = take && !sep;
      close  = (take && sep) || (take_byte && is_last);
      fresh  = (tlen_ff == '0);

      if (take) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (char_in == 8'h00) ended_in = 1'b1;
      end

      // Append one byte to the current token
      if (append) begin
         if (fresh) begin
            k = !is_digit(char_in) ? TK_WORD : (roles_ff[1] ? TK_DIGIT : TK_DAY);
            lead_in = RD_INIT; r1_in = RD_INIT; r2_in = RD_INIT;
            bdash = 2'd0; bcolon = 2'd0; bseg = 2'd0;
            after_in = '0;
            d0_in = char_in[3:0];
         end else begin
            k = kind_ff;
            bdash = dash_ff; bcolon = colon_ff; bseg = seg_ff;
         end
         kind_in = k;
         lead_in = rd_step(fresh ? RD_INIT : lead_ff, char_in);
         if (tlen_ff == CNT_W'(1)) b1_in = char_in;
         dash_in  = bdash;
         colon_in = bcolon;
         seg_in   = bseg;
         if (k == TK_DAY && char_in == 8'h2D && bdash != 2'd2) dash_in = bdash + 2'd1;
         if (k == TK_DIGIT && char_in == 8'h3A && bcolon != 2'd2) colon_in = bcolon + 2'd1;
         // month text capture
         if ((k == TK_WORD || (k == TK_DAY && bdash == 2'd1 && char_in != 8'h2D))
             && bseg != 2'd3) begin
            unique case (bseg)
               2'd0:    pre_in[23:16] = char_in;
               2'd1:    pre_in[15:8]  = char_in;
               default: pre_in[7:0]   = char_in;
            endcase
            seg_in = bseg + 2'd1;
         end
         if ((k == TK_DAY && bdash == 2'd2) || (k == TK_DIGIT && bcolon != 2'd0)) begin
            r1_in = rd_step(fresh ? RD_INIT : r1_ff, char_in);
         end
         if (k == TK_DAY && bdash == 2'd2) after_in = after_ff + CNT_W'(1);
         if (k == TK_DIGIT && bcolon == 2'd2) r2_in = rd_step(r2_ff, char_in);
         tlen_in = tlen_ff + CNT_W'(1);
      end

      // Close the token and assign its role
      if (close) begin
         if (tlen_in != '0 && !err_ff) begin
            unique case (kind_in)
               TK_DAY: begin
                  roles_in[1] = 1'b1;
                  day_in = rd_value(lead_in);
                  if (dash_in == 2'd1) begin
                     err_in = 1'b1;
                  end else if (dash_in == 2'd2) begin
                     roles_in[2] = 1'b1;
                     roles_in[3] = 1'b1;
                     month_in = (seg_in == 2'd3) ? month_match(pre_in) : MON_NONE;
                     year_in  = rd_value(r1_in);
                     ylen_in  = after_in;
                  end
               end
               TK_DIGIT: begin
                  if (colon_in != 2'd0) begin
                     roles_in[4] = 1'b1;
                     hour_in = $signed({1'b0, 10'(d0_in) * 10'd10})
                             + $signed({3'b0, b1_in}) - 11'sd48;
                     min_in  = rd_value(r1_in);
                     sec_in  = (colon_in == 2'd2) ? rd_value(r2_in) : '0;
                  end else if (!roles_ff[3]) begin
                     roles_in[3] = 1'b1;
                     year_in = rd_value(lead_in);
                     ylen_in = tlen_in;
                  end
               end
               TK_WORD: begin
                  if (!roles_ff[0]) begin
                     roles_in[0] = 1'b1;
                  end else if (!roles_ff[2]) begin
                     roles_in[2] = 1'b1;
                     month_in = (seg_in == 2'd3) ? month_match(pre_in) : MON_NONE;
                  end else if (!roles_ff[5]) begin
                     roles_in[5] = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         tlen_in = '0;
      end

      push_fields.err      = err_in;
      push_fields.have_all = roles_in[1] && roles_in[2] && roles_in[3] && roles_in[4];
      push_fields.day      = day_in;
      push_fields.month    = month_in;
      push_fields.year     = year_in;
      push_fields.ylen     = ylen_in;
      push_fields.hour     = hour_in;
      push_fields.min      = min_in;
      push_fields.sec      = sec_in;

      // End of string: hand off and start over
      if (take_byte && is_last) begin
         push     = 1'b1;
         cnt_in   = '0;       ended_in = 1'b0;    tlen_in = '0;
         roles_in = '0;       err_in   = 1'b0;    day_in  = '0;
         month_in = MON_NONE; year_in  = '0;      ylen_in = '0;
         hour_in  = '0;       min_in   = '0;      sec_in  = '0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         ended_ff <= 1'b0;
         tlen_ff  <= '0;
         roles_ff <= '0;
         err_ff   <= 1'b0;
         kind_ff  <= TK_NONE;
         month_ff <= MON_NONE;
         day_ff   <= '0;
         year_ff  <= '0;
         ylen_ff  <= '0;
         hour_ff  <= '0;
         min_ff   <= '0;
         sec_ff   <= '0;
      end else begin
         cnt_ff   <= cnt_in;
         ended_ff <= ended_in;
         tlen_ff  <= tlen_in;
         roles_ff <= roles_in;
         err_ff   <= err_in;
         kind_ff  <= kind_in;
         month_ff <= month_in;
         day_ff   <= day_in;
         year_ff  <= year_in;
         ylen_ff  <= ylen_in;
         hour_ff  <= hour_in;
         min_ff   <= min_in;
         sec_ff   <= sec_in;
      end
   end

   // Token working registers, qualified by tlen_ff
   always_ff @(posedge clock) begin
      lead_ff  <= lead_in;
      r1_ff    <= r1_in;
      r2_ff    <= r2_in;
      dash_ff  <= dash_in;
      colon_ff <= colon_in;
      seg_ff   <= seg_in;
      pre_ff   <= pre_in;
      after_ff <= after_in;
      d0_ff    <= d0_in;
      b1_ff    <= b1_in;
   end

endmodule

FILE: rtl/core/hdp_queue.sv
// Two-entry queue of parsed field records between front and back.
module hdp_queue
   import hdp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  fields_type push_fields,
   output logic       full,
   output logic       not_empty,
   input  logic       pop,
   output fields_type pop_fields
);

   fields_type  mem_ff [2];
   logic        wr_ff, wr_in;
   logic        rd_ff, rd_in;
   logic [1:0]  cnt_ff, cnt_in;

   assign full       = (cnt_ff == 2'd2);
   assign not_empty  = (cnt_ff != 2'd0);
   assign pop_fields = mem_ff[rd_ff];

   // Pointer and count update
   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_fields;
   end

endmodule

FILE: rtl/core/hdp_back.sv
// Range checks, year pivot and epoch seconds arithmetic, one string at a time.
module hdp_back
   import hdp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  fields_type                 q_fields,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_ok,
   output logic signed [EPOCH_W-1:0]  rsp_epoch_seconds
);

   localparam logic [23:0] RECIP_25 = 24'd167773;   // ceil(2^22 / 25)

   bk_state_type state_ff, state_in;
   fields_type   f_ff, f_in;
   logic         good_ff, good_in;
   logic [18:0]  yp_ff, yp_in;              // shifted March-based year, never negative
   logic [9:0]   extra_ff, extra_in;        // day of year from March plus day - 1
   logic [28:0]  d365_ff, d365_in;
   logic [16:0]  q4_ff, q4_in;
   logic [14:0]  q100_ff, q100_in;
   logic [12:0]  q400_ff, q400_in;
   logic [16:0]  tod_ff, tod_in;
   logic signed [30:0] days_ff, days_in;
   logic         out_v_ff, out_v_in;
   logic         out_ok_ff, out_ok_in;
   logic signed [EPOCH_W-1:0] out_s_ff, out_s_in;

   assign rsp_valid         = out_v_ff;
   assign rsp_ok            = out_ok_ff;
   assign rsp_epoch_seconds = out_s_ff;

   always_comb begin
      logic signed [19:0] yr;
      logic signed [20:0] y;
      logic [40:0]        p100, p400;
      logic signed [47:0] prod;
      state_in = state_ff;  f_in = f_ff;       good_in = good_ff;  yp_in = yp_ff;
      extra_in = extra_ff;  d365_in = d365_ff; q4_in = q4_ff;      q100_in = q100_ff;
      q400_in = q400_ff;    tod_in = tod_ff;   days_in = days_ff;
      out_v_in = out_v_ff && !rsp_ready;
      out_ok_in = out_ok_ff; out_s_in = out_s_ff;
      q_pop = 1'b0;
      yr = '0; y = '0; p100 = '0; p400 = '0; prod = '0;

      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               f_in     = q_fields;
               state_in = BK_PREP;
            end
         end
         // checks and year pivot
         BK_PREP: begin
            good_in = !f_ff.err && f_ff.have_all && (f_ff.month < MON_NONE)
                    && (f_ff.sec >= 0) && (f_ff.sec <= 59)
                    && (f_ff.min >= 0) && (f_ff.min <= 59)
                    && (f_ff.hour >= 0) && (f_ff.hour <= 23)
                    && (f_ff.day >= 1) && (f_ff.day <= 31);
            yr = 20'(f_ff.year);
            if (f_ff.ylen == CNT_W'(4)) yr = yr - 20'sd1900;
            else if (f_ff.year < 70) yr = yr + 20'sd100;
            else if (f_ff.year > 19000) yr = yr - 20'sd19000;
            y = 21'(yr) + 21'sd1900 - ((f_ff.month < 4'd2) ? 21'sd1 : 21'sd0) + 21'sd160000;
            yp_in    = y[18:0];
            extra_in = 10'(month_offset(f_ff.month)) + 10'(f_ff.day[4:0]) - 10'd1;
            state_in = BK_MUL;
         end
         // constant multiplies for the leap corrections and time of day
         BK_MUL: begin
            p100     = 41'(yp_ff[18:2]) * 41'(RECIP_25);
            p400     = 41'(yp_ff[18:4]) * 41'(RECIP_25);
            d365_in  = 29'(yp_ff) * 29'd365;
            q4_in    = yp_ff[18:2];
            q100_in  = p100[36:22];
            q400_in  = p400[34:22];
            tod_in   = 17'(f_ff.hour[4:0]) * 17'd3600 + 17'(f_ff.min[5:0]) * 17'd60
                     + 17'(f_ff.sec[5:0]);
            state_in = BK_SUM;
         end
         BK_SUM: begin
            days_in  = $signed({2'b0, d365_ff}) + $signed(31'(q4_ff)) - $signed(31'(q100_ff))
                     + $signed(31'(q400_ff)) + $signed(31'(extra_ff))
                     - 31'sd719468 - 31'sd58438800;
            state_in = BK_SCALE;
         end
         // scale to seconds into the output register
         BK_SCALE: begin
            if (!out_v_ff || rsp_ready) begin
               prod      = 48'(days_ff) * 48'sd86400 + 48'(tod_ff);
               out_v_in  = 1'b1;
               out_ok_in = good_ff;
               out_s_in  = good_ff ? prod[EPOCH_W-1:0] : '1;
               state_in  = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      f_ff      <= f_in;
      good_ff   <= good_in;
      yp_ff     <= yp_in;
      extra_ff  <= extra_in;
      d365_ff   <= d365_in;
      q4_ff     <= q4_in;
      q100_ff   <= q100_in;
      q400_ff   <= q400_in;
      tod_ff    <= tod_in;
      days_ff   <= days_in;
      out_ok_ff <= out_ok_in;
      out_s_ff  <= out_s_in;
   end

endmodule

FILE: rtl/core/hdp_checker.sv
// Port-level checks of the HTTP date parser, bound to the top level.
module hdp_checker
   import hdp_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_ok,
   input logic signed [EPOCH_W-1:0]  rsp_epoch_seconds
);

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_epoch_seconds) && $stable(rsp_ok))
      else $error("result changed while stalled");

   // an error result always carries minus one
   a_err_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_epoch_seconds == '1)
      else $error("error result without -1 seconds");

   // nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind http_date_parser_unit hdp_checker u_hdp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_ok            (rsp_ok),
   .rsp_epoch_seconds (rsp_epoch_seconds)
);

FILE: bench/http_date_parser_unit_tb.sv
// Testbench for the HTTP date parser: directed and random date strings, checked per result.
`timescale 1ns / 100ps

module http_date_parser_unit_tb;
   import hdp_pkg::*;

   localparam int TEXT_LIMIT = 127;

   typedef struct {
      logic              ok;
      logic [EPOCH_W-1:0] secs;
   } date_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [7:0]                req_char_in = 8'h00;
   logic                      req_is_last = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_ok;
   logic signed [EPOCH_W-1:0] rsp_epoch_seconds;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int bytes_sent = 0;
   date_result_type pending_dates[$];

   // Parser state as predicted byte by byte
   logic [7:0] tok_text[TEXT_LIMIT];
   int tok_len, text_count;
   bit text_done, seen_wday, seen_day, seen_month, seen_year, seen_clock, seen_zone, split_err;
   int day_num, month_num, year_num, year_len, hour_num, min_num, sec_num;

   http_date_parser_unit u_dut (.*);

   always #5 clock = ~clock;

   function automatic bit is_dig(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_ws(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic void clear_parse();
      tok_len = 0; text_count = 0; text_done = 0;
      seen_wday = 0; seen_day = 0; seen_month = 0; seen_year = 0;
      seen_clock = 0; seen_zone = 0; split_err = 0;
      day_num = 0; month_num = 12; year_num = 0; year_len = 0;
      hour_num = 0; min_num = 0; sec_num = 0;
   endfunction

   // atoi over tok_text[lo, hi), magnitude saturating
   function automatic int atoi_span(int lo, int hi);
      int i;
      bit neg;
      int mag;
      i = lo; neg = 0; mag = 0;
      while (i < hi && is_ws(tok_text[i])) i++;
      if (i < hi && (tok_text[i] == "+" || tok_text[i] == "-")) begin
         neg = tok_text[i] == "-";
         i++;
      end
      while (i < hi && is_dig(tok_text[i])) begin
         mag = mag * 10 + int'(tok_text[i] - "0");
         if (mag > 131071) mag = 131071;
         i++;
      end
      return neg ? -mag : mag;
   endfunction

   function automatic int find_in_tok(logic [7:0] c, int lo, int hi);
      for (int i = lo; i < hi; i++) if (tok_text[i] == c) return i;
      return hi;
   endfunction

   function automatic int month_of(int lo, int hi);
      string names;
      logic [7:0] a, b, c;
      names = "JanFebMarAprMayJunJulAugSepOctNovDec";
      if (hi < lo + 3) return 12;
      a = tok_text[lo]; b = tok_text[lo+1]; c = tok_text[lo+2];
      if (a >= "a" && a <= "z") a = a - 8'd32;
      if (b >= "A" && b <= "Z") b = b + 8'd32;
      if (c >= "A" && c <= "Z") c = c + 8'd32;
      for (int k = 0; k < 12; k++)
         if (a == names[3*k] && b == names[3*k+1] && c == names[3*k+2]) return k;
      return 12;
   endfunction

   // Assign the finished token to its date field
   function automatic void close_tok();
      int n, d1, d2, c1, c2;
      n = tok_len;
      tok_len = 0;
      if (n == 0 || split_err) return;
      if (is_dig(tok_text[0])) begin
         if (!seen_day) begin
            seen_day = 1;
            day_num = atoi_span(0, n);
            d1 = find_in_tok("-", 0, n);
            if (d1 < n) begin
               d2 = find_in_tok("-", d1 + 1, n);
               if (d2 >= n) begin
                  split_err = 1;
                  return;
               end
               seen_month = 1; seen_year = 1;
               month_num = month_of(d1 + 1, d2);
               year_num = atoi_span(d2 + 1, n);
               year_len = n - d2 - 1;
            end
         end else if (find_in_tok(":", 0, n) < n) begin
            c1 = find_in_tok(":", 0, n);
            c2 = find_in_tok(":", c1 + 1, n);
            seen_clock = 1;
            hour_num = 10 * int'(tok_text[0] - "0") + (int'(tok_text[1]) - 48);
            min_num = atoi_span(c1 + 1, n);
            sec_num = (c2 < n) ? atoi_span(c2 + 1, n) : 0;
         end else if (!seen_year) begin
            seen_year = 1;
            year_num = atoi_span(0, n);
            year_len = n;
         end
      end else if (!seen_wday) seen_wday = 1;
      else if (!seen_month) begin
         seen_month = 1;
         month_num = month_of(0, n);
      end else if (!seen_zone) seen_zone = 1;
   endfunction

   function automatic longint days_from_epoch(longint y, longint m, longint d);
      longint era, yoe, doy, doe;
      if (m <= 2) y -= 1;
      era = (y >= 0 ? y : y - 399) / 400;
      yoe = y - era * 400;
      doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe - 719468;
   endfunction

   function automatic date_result_type date_of_text();
      date_result_type r;
      longint yr, secs;
      r.ok = 0;
      r.secs = '1;
      if (split_err || !(seen_day && seen_month && seen_year && seen_clock)) return r;
      if (month_num >= 12) return r;
      yr = year_num;
      if (year_len == 4) yr -= 1900;
      else if (yr < 70) yr += 100;
      else if (yr > 19000) yr -= 19000;
      if (sec_num < 0 || sec_num > 59 || min_num < 0 || min_num > 59) return r;
      if (hour_num < 0 || hour_num > 23 || day_num < 1 || day_num > 31) return r;
      secs = (days_from_epoch(yr + 1900, month_num + 1, 1) + day_num - 1) * 86400
             + hour_num * 3600 + min_num * 60 + sec_num;
      r.ok = 1;
      r.secs = secs[EPOCH_W-1:0];
      return r;
   endfunction

   // Predict one accepted byte
   function automatic void take_byte(logic [7:0] c, logic last);
      if (!text_done && text_count < TEXT_LIMIT) begin
         text_count++;
         if (c == 8'h00) begin
            text_done = 1;
            close_tok();
         end else if (c == "," || c == " ") close_tok();
         else if (tok_len < TEXT_LIMIT) begin
            tok_text[tok_len] = c;
            tok_len++;
         end
      end
      if (last) begin
         close_tok();
         pending_dates.push_back(date_of_text());
         clear_parse();
      end
   endfunction

   // One byte transfer, with random sender gaps
   task automatic send_byte(logic [7:0] c, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_in <= c;
      req_is_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      take_byte(c, last);
      bytes_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   // Result check against the oldest prediction
   always @(posedge clock) begin
      date_result_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_dates.size() == 0) begin
            $display("%0t: unexpected result ok=%0b secs=%0d", $time, rsp_ok, rsp_epoch_seconds);
            error_count++;
         end else begin
            w = pending_dates.pop_front();
            if (rsp_ok !== w.ok) begin
               $display("%0t: ok expected %0b actual %0b", $time, w.ok, rsp_ok);
               error_count++;
            end
            if (rsp_epoch_seconds !== w.secs) begin
               $display("%0t: epoch_seconds expected %0d actual %0d", $time,
                        $signed(w.secs), rsp_epoch_seconds);
               error_count++;
            end
         end
      end
   end

   // Receiver stalls
   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   function automatic string mixed_case(string s);
      string r;
      r = s;
      for (int i = 0; i < r.len(); i++)
         if ($urandom_range(3) == 0 && ((r[i] >= "a" && r[i] <= "z") || (r[i] >= "A" && r[i] <= "Z")))
            r[i] = r[i] ^ 8'h20;
      return r;
   endfunction

   function automatic string random_date();
      string wd, mon, s;
      int d, h, m, sec, y, w;
      wd = "MonTueWedThuFriSatSun";
      s = "JanFebMarAprMayJunJulAugSepOctNovDec";
      w = $urandom_range(6);
      wd = wd.substr(3 * w, 3 * w + 2);
      mon = ($urandom_range(15) == 0) ? "Xyz" : mixed_case(s.substr(0, 35));
      if (mon != "Xyz") begin
         int k;
         k = $urandom_range(11);
         mon = mixed_case(s.substr(3 * k, 3 * k + 2));
      end
      d = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(31, 1);
      h = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(23);
      m = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(59);
      sec = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(59);
      y = $urandom_range(2200, 1600);
      case ($urandom_range(2))
         0: s = $sformatf("%s, %02d %s %04d %02d:%02d:%02d GMT", wd, d, mon, y, h, m, sec);
         1: s = $sformatf("%sday, %02d-%s-%02d %02d:%02d:%02d GMT", wd, d, mon,
                          $urandom_range(99), h, m, sec);
         default: s = $sformatf("%s %s %2d %02d:%02d:%02d %0d", wd, mon, d, h, m, sec,
                                ($urandom_range(4) == 0) ? $urandom_range(25000) : y);
      endcase
      // Occasional damage: a random byte or a cut
      if ($urandom_range(5) == 0) s[$urandom_range(s.len() - 1)] = 8'($urandom_range(255));
      if ($urandom_range(9) == 0) s = s.substr(0, $urandom_range(s.len() - 1));
      return s;
   endfunction

   task automatic send_noise();
      int n;
      n = $urandom_range(24, 1);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)), i == n - 1);
   endtask

   task automatic test_layouts();
      send_text("Sun, 06 Nov 1994 08:49:37 GMT");
      send_text("Sunday, 06-Nov-94 08:49:37 GMT");
      send_text("Sun Nov  6 08:49:37 1994");
      send_text("Sat, 01 Jan 0000 00:00:00 GMT");
      send_text("Fri, 31 Dec 9999 23:59:59 GMT");
      send_text("Mon, 31 DECEMBER 131071 23:59:59 UTC");
      send_text("Thu, 01 jAN 69 00:00:00");
      send_text("Thu, 01 Jan 70 00:00:00");
      send_text("Thu, 01 Jan 19500 00:00:00");
   endtask

   task automatic test_edges();
      string head;
      head = "Sun, 06 Nov 1994 08:49:37";
      send_text("Sun, 06-Nov 1994 08:49:37 GMT");
      send_text("Sun, 06 Nov 1994 GMT");
      send_text("Sun, 00 Nov 1994 08:49:37");
      send_text("Sun, 32 Nov 1994 08:49:37");
      send_text("Sun, 06 Nov 1994 24:00:00");
      send_text("Sun, 06 Nov 1994 08:60:00");
      send_text("Sun, 06 Nov 1994 08:00:-1");
      send_text("Sun, 06 Ja 1994 08:00");
      send_text("Sun, 06 Qux 1994 8x:30");
      send_text("Sun, 31 Feb 99999999 8:30 ,");
      // NUL ends the text, the rest is ignored
      for (int i = 0; i < head.len(); i++) send_byte(head[i], 1'b0);
      send_byte(8'h00, 1'b0);
      send_text(" garbage 12");
      send_text({"Sun, 06 Nov 1994 08:49:37 ", {110{" "}}, "X"});
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_random_traffic(int n_bytes);
      int stop_at;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at)
         if ($urandom_range(9) < 8) send_text(random_date());
         else send_noise();
   endtask

   // Main sequence
   initial begin
      clear_parse();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 31; recv_idle_pct = 55;
      test_layouts();
      test_edges();
      test_random_traffic(330);
      send_idle_pct = 55; recv_idle_pct = 31;
      test_random_traffic(330);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random_traffic(330);
      req_valid <= 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) $display("http_date_parser_unit_tb: clean");
      else $display("http_date_parser_unit_tb: errors");
      $finish;
   end

   // Watchdog
   initial begin
      #5000000;
      $display("http_date_parser_unit_tb: errors");
      $finish;
   end

endmodule
